### sv/ipv4c_pkg.sv
// shared types and constants for the dotted ipv4 address checker
`default_nettype none
package ipv4c_pkg;

  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] OCTET_MAX = 8'd255;
  localparam logic [2:0] DOTS_NEEDED = 3'd3;
  localparam logic [2:0] DOT_SAT = 3'd7;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_LEAD_DOT   = 3'd1,
    ERR_LEAD_ZERO  = 3'd2,
    ERR_BAD_CHAR   = 3'd3,
    ERR_DOUBLE_DOT = 3'd4,
    ERR_OCTET      = 3'd5,
    ERR_TRAIL_DOT  = 3'd6,
    ERR_DOT_COUNT  = 3'd7
  } err_t;

  // classified character as it travels from front to back
  typedef struct packed {
    logic       is_dot;
    logic       is_zero;
    logic       is_digit;
    logic [3:0] digit;
    logic       last;
  } cls_t;

endpackage
`default_nettype wire

### sv/ipv4_dotted_address_checker_top.sv
// top level of the dotted ipv4 address checker
// usage
//   input channel: one ascii character per item on in_character, in_last high on
//   the final character of a string. an item is taken on a rising edge with
//   in_valid high and in_stall low
//   result channel: one item per string on out_valid_res / out_error_code, given
//   when the final character has been scanned. taken when out_valid is high and
//   out_stall is low
//   error codes: 0 ok, 1 leading dot, 2 leading zero, 3 bad char, 4 double dot,
//   5 octet above 255, 6 trailing dot, 7 dot count not three
// timing
//   one character per cycle sustained while the result channel is not stalled;
//   the scan state update in the back end is a single step per character
//   when the queue is empty, the final character is first written into the
//   queue, then popped by the scan, which registers out_valid high
// reset
//   synchronous, active low: queue empties, scan state returns to start of a
//   string, out_valid drops
// stall
//   a stalled result holds; non-final characters keep draining, a final one waits
//   in the two-entry queue, and in_stall rises once the queue is full
`default_nettype none
module ipv4_dotted_address_checker_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_character,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_valid_res,
  output logic      [2:0] out_error_code
);

  ipv4c_pkg::cls_t cls;       // classified character from the front
  ipv4c_pkg::cls_t q_head;    // oldest queued character
  logic            q_full;
  logic            q_valid;
  logic            q_pop;

  // front: classify the character as it arrives
  ipv4c_front u_front (
    .character (in_character),
    .last      (in_last),
    .cls       (cls)
  );

  // queue decouples the input handshake from the scan
  ipv4c_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  assign in_stall = q_full;

  // back: scan state, sticky error, result register
  ipv4c_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_valid_res  (out_valid_res),
    .out_error_code (out_error_code)
  );

endmodule
`default_nettype wire

### sv/ipv4c_front.sv
// front end: classifies each incoming character
`default_nettype none
module ipv4c_front (
  input  wire logic           [7:0] character,
  input  wire logic                 last,
  output ipv4c_pkg::cls_t           cls
);

  logic [7:0] diff;

  assign diff = character - ipv4c_pkg::CHAR_ZERO;

  always_comb begin
    cls.is_dot   = (character == ipv4c_pkg::CHAR_DOT);
    cls.is_zero  = (character == ipv4c_pkg::CHAR_ZERO);
    cls.is_digit = (character >= ipv4c_pkg::CHAR_ZERO) && (character <= ipv4c_pkg::CHAR_NINE);
    cls.digit    = diff[3:0];
    cls.last     = last;
  end

endmodule
`default_nettype wire

### sv/ipv4c_queue.sv
// short queue of classified characters between front and back
`default_nettype none
module ipv4c_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire ipv4c_pkg::cls_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output ipv4c_pkg::cls_t      head
);

  ipv4c_pkg::cls_t                  mem_r [ipv4c_pkg::QDEPTH];
  logic [ipv4c_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ipv4c_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ipv4c_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                             do_push, do_pop;

  assign full      = (count_r == ipv4c_pkg::QCNT_W'(ipv4c_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointers wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ipv4c_pkg::QPTR_W'(ipv4c_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ipv4c_pkg::QPTR_W'(ipv4c_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### sv/ipv4c_back.sv
// back end: scan state, sticky error and the result register
`default_nettype none
module ipv4c_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire ipv4c_pkg::cls_t q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_valid_res,
  output logic           [2:0] out_error_code
);

  logic                at_start_r, at_start_nxt;
  logic                prev_dot_r, prev_dot_nxt;
  logic [2:0]          dots_r, dots_nxt;
  logic [7:0]          octet_r, octet_nxt;
  ipv4c_pkg::err_t     ferr_r, ferr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                res_ok_r, res_ok_nxt;
  ipv4c_pkg::err_t     res_code_r, res_code_nxt;
  ipv4c_pkg::err_t     scan_err, code;
  logic [11:0]         octet_x10;

  assign out_valid      = out_valid_r;
  assign out_valid_res  = res_ok_r;
  assign out_error_code = res_code_r;

  // only a final character needs the result slot
  assign q_pop = q_valid && (!q_head.last || !out_valid_r || !out_stall);

  assign octet_x10 = {1'b0, octet_r, 3'b000} + {3'b000, octet_r, 1'b0} + {8'd0, q_head.digit};

  always_comb begin
    at_start_nxt  = at_start_r;
    prev_dot_nxt  = prev_dot_r;
    dots_nxt      = dots_r;
    octet_nxt     = octet_r;
    ferr_nxt      = ferr_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_ok_nxt    = res_ok_r;
    res_code_nxt  = res_code_r;
    scan_err      = ipv4c_pkg::ERR_NONE;
    code          = ipv4c_pkg::ERR_NONE;

    if (at_start_r && q_head.is_dot) begin
      scan_err = ipv4c_pkg::ERR_LEAD_DOT;
    end else if (at_start_r && q_head.is_zero) begin
      scan_err = ipv4c_pkg::ERR_LEAD_ZERO;
    end else if (!q_head.is_digit && !q_head.is_dot) begin
      scan_err = ipv4c_pkg::ERR_BAD_CHAR;
    end else if (q_head.is_dot && prev_dot_r) begin
      scan_err = ipv4c_pkg::ERR_DOUBLE_DOT;
    end else if (!q_head.is_dot && (octet_x10 > {4'd0, ipv4c_pkg::OCTET_MAX})) begin
      scan_err = ipv4c_pkg::ERR_OCTET;
    end

    if (q_pop) begin
      at_start_nxt = 1'b0;
      if (ferr_r == ipv4c_pkg::ERR_NONE) begin
        ferr_nxt = scan_err;
        if (scan_err == ipv4c_pkg::ERR_NONE) begin
          prev_dot_nxt = q_head.is_dot;
          if (q_head.is_dot) begin
            octet_nxt = '0;
            if (dots_r != ipv4c_pkg::DOT_SAT) begin
              dots_nxt = dots_r + 1'b1;
            end
          end else begin
            octet_nxt = octet_x10[7:0];
          end
        end
      end

      if (q_head.last) begin
        code = ferr_nxt;
        if (code == ipv4c_pkg::ERR_NONE) begin
          if (q_head.is_dot) begin
            code = ipv4c_pkg::ERR_TRAIL_DOT;
          end else if (dots_nxt != ipv4c_pkg::DOTS_NEEDED) begin
            code = ipv4c_pkg::ERR_DOT_COUNT;
          end
        end
        out_valid_nxt = 1'b1;
        res_ok_nxt    = (code == ipv4c_pkg::ERR_NONE);
        res_code_nxt  = code;
        // ready for the next string
        at_start_nxt  = 1'b1;
        prev_dot_nxt  = 1'b0;
        dots_nxt      = '0;
        octet_nxt     = '0;
        ferr_nxt      = ipv4c_pkg::ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r  <= 1'b1;
      prev_dot_r  <= 1'b0;
      dots_r      <= '0;
      octet_r     <= '0;
      ferr_r      <= ipv4c_pkg::ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      at_start_r  <= at_start_nxt;
      prev_dot_r  <= prev_dot_nxt;
      dots_r      <= dots_nxt;
      octet_r     <= octet_nxt;
      ferr_r      <= ferr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_ok_r   <= res_ok_nxt;
    res_code_r <= res_code_nxt;
  end

endmodule
`default_nettype wire

### sv/ipv4c_checker.sv
// port-level checks for the dotted ipv4 address checker, bound to the top level
`default_nettype none
module ipv4c_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_character,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_valid_res,
  input wire logic [2:0] out_error_code
);

  // after reset the input is not stalled and no result is pending
  a_reset_clear: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (!in_stall && !out_valid))
    else $error("state not cleared by reset");

  // the pass flag agrees with the error code
  a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_res == (out_error_code == ipv4c_pkg::ERR_NONE)))
    else $error("pass flag and error code disagree");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_valid_res) && $stable(out_error_code)))
    else $error("stalled result changed");

  // the queue cannot fill while nothing was offered
  a_stall_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(in_stall) && $past(rst_n)) |-> $past(in_valid))
    else $error("input stall rose without an offered item");

endmodule

bind ipv4_dotted_address_checker_top ipv4c_checker u_ipv4c_checker (.*);
`default_nettype wire
